// ----- rtl/core/tlshx_pkg.sv -----
// ----------------------------------------------------------------------------
// tlshx_pkg
// Shared types, phase codes, token codes and helpers for the TLS hello
// field extractor.
// ----------------------------------------------------------------------------
package tlshx_pkg;

	// parse phases
	typedef enum logic [4:0] {
		PH_HDR       = 5'd0,
		PH_RANDOM    = 5'd1,
		PH_SID_LEN   = 5'd2,
		PH_SID       = 5'd3,
		PH_CS_LEN    = 5'd4,
		PH_CS_LIST   = 5'd5,
		PH_CM_LEN    = 5'd6,
		PH_CM_LIST   = 5'd7,
		PH_EXTS_LEN  = 5'd8,
		PH_EXT_HDR   = 5'd9,
		PH_SKIP      = 5'd10,
		PH_SNI_LL    = 5'd11,
		PH_SNI_HDR   = 5'd12,
		PH_SNI_NAME  = 5'd13,
		PH_ALPN_LL   = 5'd14,
		PH_ALPN_LEN  = 5'd15,
		PH_ALPN_NAME = 5'd16,
		PH_U16_LL    = 5'd17,
		PH_U16_ITEMS = 5'd18,
		PH_U8_LL     = 5'd19,
		PH_PF_ITEMS  = 5'd20,
		PH_SRV_VER   = 5'd21,
		PH_DONE      = 5'd22,
		PH_DRAIN     = 5'd23
	} phase_t;

	// token kinds
	localparam logic [3:0] TK_SUITE   = 4'd0;
	localparam logic [3:0] TK_EXT     = 4'd1;
	localparam logic [3:0] TK_GROUP   = 4'd2;
	localparam logic [3:0] TK_PTFMT   = 4'd3;
	localparam logic [3:0] TK_SIGALG  = 4'd4;
	localparam logic [3:0] TK_VERSION = 4'd5;
	localparam logic [3:0] TK_SNI     = 4'd6;
	localparam logic [3:0] TK_ALPN    = 4'd7;
	localparam logic [3:0] TK_HELLO   = 4'd8;
	localparam logic [3:0] TK_ACCEPT  = 4'd9;
	localparam logic [3:0] TK_REJECT  = 4'd10;

	// extension types
	localparam logic [15:0] EXT_SNI      = 16'd0;
	localparam logic [15:0] EXT_GROUPS   = 16'd10;
	localparam logic [15:0] EXT_PTFMT    = 16'd11;
	localparam logic [15:0] EXT_SIGALG   = 16'd13;
	localparam logic [15:0] EXT_ALPN     = 16'd16;
	localparam logic [15:0] EXT_VERSIONS = 16'd43;

	localparam logic [15:0] GREASE_MASK = 16'hFAFA;

	// one result transaction
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] value;
		logic [15:0] elen;
		logic        nend;
		logic        last;
	} result_t;

	// grease-style code points: nonzero, both bytes equal, bits only within GREASE_MASK
	function automatic logic is_grease(input logic [15:0] v);
		return (v != 16'd0) && ((v & ~GREASE_MASK) == 16'd0) && (v[7:0] == v[15:8]);
	endfunction

endpackage

// ----- rtl/core/tls_hello_field_extractor.sv -----
// ----------------------------------------------------------------------------
// tls_hello_field_extractor
// Parses TLS Client/Server Hello from payload bytes and emits field tokens
// plus one accept/reject verdict per packet.
// ----------------------------------------------------------------------------
// Order: a token is written into the result queue when its byte is taken and leaves after earlier results.
// Throughput: one byte per cycle while in_ready shows queue room; a byte yields at most two transactions
// (a token and the verdict), drained one per cycle while out_ready is high from a 4-entry queue.
// Reset: arst_n clears parser state and the result queue.
module tls_hello_field_extractor #(
	parameter int PACKET_LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic        final_byte,
	input  logic [15:0] packet_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [15:0] token_value,
	output logic [15:0] ext_length,
	output logic        name_end,
	output logic        run_last
);

	localparam int PL = PACKET_LENGTH_BITS;
	localparam logic [PL-1:0] OFF_MAX = {PL{1'b1}};

	// parser state
	tlshx_pkg::phase_t phase_q;
	logic [PL-1:0] off_q;
	logic          srv_q, rej_q;
	logic [15:0]   sec_q, ext_q, lst_q, itm_q, cet_q, vs_q;

	tlshx_pkg::phase_t ph, ph0;
	logic [PL-1:0] off_n;
	logic          srv, rej;
	logic [15:0]   sec, ext, lst, itm, cet, vs, v16;
	logic          tok_v;
	logic [3:0]    tok_k;
	logic [15:0]   tok_val, tok_len;
	logic          tok_end;
	logic          sni_go, sb_go, ne_go, bad, ok;
	logic [PL-1:0] plen;
	logic [17:0]   ext_end;

	assign plen = packet_bytes[PL-1:0];

	// next state and token for one byte
	always_comb begin
		ph = phase_q; ph0 = phase_q;
		srv = srv_q; rej = rej_q;
		sec = sec_q; ext = ext_q; lst = lst_q; itm = itm_q; cet = cet_q; vs = vs_q;
		off_n = off_q;
		tok_v = 1'b0; tok_k = tlshx_pkg::TK_SUITE; tok_val = '0; tok_len = '0; tok_end = 1'b0;
		sni_go = 1'b0; sb_go = 1'b0; ne_go = 1'b0; bad = 1'b0; ok = 1'b0;
		v16 = {vs[7:0], payload_byte};
		ext_end = '0;
		if (off_q < plen) begin
			if (phase_q <= tlshx_pkg::PH_EXTS_LEN) begin
				unique case (phase_q)
					tlshx_pkg::PH_HDR: begin
						bad = (off_q == PL'(0) && payload_byte != 8'd22)
							|| ((off_q == PL'(1) || off_q == PL'(9)) && payload_byte != 8'd3)
							|| (off_q == PL'(2) && payload_byte > 8'd3)
							|| (off_q == PL'(5) && payload_byte != 8'd1 && payload_byte != 8'd2)
							|| (off_q == PL'(10) && (payload_byte < 8'd1 || payload_byte > 8'd3));
						if (bad) begin
							rej = 1'b1; ph = tlshx_pkg::PH_DRAIN;
						end else begin
							if (off_q == PL'(5)) srv = (payload_byte == 8'd2);
							if (off_q == PL'(10)) begin
								tok_v = 1'b1; tok_k = tlshx_pkg::TK_HELLO;
								tok_val = srv ? 16'd2 : 16'd1;
								ph = tlshx_pkg::PH_RANDOM; sec = 16'd32;
							end
						end
					end
					tlshx_pkg::PH_RANDOM, tlshx_pkg::PH_SID: begin
						if (sec != 16'd0) sec = sec - 16'd1;
						if (sec == 16'd0) begin
							if (phase_q == tlshx_pkg::PH_RANDOM) ph = tlshx_pkg::PH_SID_LEN;
							else begin
								ph = tlshx_pkg::PH_CS_LEN; itm = 16'd2; vs = '0;
							end
						end
					end
					tlshx_pkg::PH_SID_LEN: begin
						sec = {8'd0, payload_byte};
						if (payload_byte != 8'd0) ph = tlshx_pkg::PH_SID;
						else begin
							ph = tlshx_pkg::PH_CS_LEN; itm = 16'd2; vs = '0;
						end
					end
					tlshx_pkg::PH_CS_LEN: begin
						vs = v16;
						if (itm != 16'd0) itm = itm - 16'd1;
						if (itm == 16'd0) begin
							if (srv) begin
								ph = tlshx_pkg::PH_CM_LIST; sec = 16'd1;
							end else begin
								sec = vs; itm = '0;
								ph = (vs != 16'd0) ? tlshx_pkg::PH_CS_LIST : tlshx_pkg::PH_CM_LEN;
							end
						end
					end
					tlshx_pkg::PH_CS_LIST: begin
						if (itm == 16'd0) begin
							vs = {8'd0, payload_byte}; itm = 16'd1;
						end else begin
							itm = '0;
							if (!tlshx_pkg::is_grease(v16)) begin
								tok_v = 1'b1; tok_k = tlshx_pkg::TK_SUITE; tok_val = v16;
							end
						end
						if (sec != 16'd0) sec = sec - 16'd1;
						if (sec == 16'd0) ph = tlshx_pkg::PH_CM_LEN;
					end
					tlshx_pkg::PH_CM_LEN: begin
						sec = {8'd0, payload_byte};
						if (payload_byte != 8'd0) ph = tlshx_pkg::PH_CM_LIST;
						else begin
							ph = tlshx_pkg::PH_EXTS_LEN; itm = 16'd2; vs = '0;
						end
					end
					tlshx_pkg::PH_CM_LIST: begin
						if (sec != 16'd0) sec = sec - 16'd1;
						if (sec == 16'd0) begin
							ph = tlshx_pkg::PH_EXTS_LEN; itm = 16'd2; vs = '0;
						end
					end
					default: begin
						// extension list length
						vs = v16;
						if (itm != 16'd0) itm = itm - 16'd1;
						if (itm == 16'd0) begin
							ext_end = 18'(off_q) + 18'd1 + 18'(vs);
							if (ext_end > 18'(plen)) begin
								rej = 1'b1; ph = tlshx_pkg::PH_DRAIN;
							end else begin
								sec = vs;
								if (vs != 16'd0) begin
									ph = tlshx_pkg::PH_EXT_HDR; itm = 16'd4; vs = '0; cet = '0;
								end else ph = tlshx_pkg::PH_DONE;
							end
						end
					end
				endcase
			end else if (phase_q == tlshx_pkg::PH_EXT_HDR) begin
				// extension type and length
				if (sec != 16'd0) sec = sec - 16'd1;
				if (itm > 16'd2) cet = {cet[7:0], payload_byte};
				else vs = v16;
				if (itm != 16'd0) itm = itm - 16'd1;
				if (itm == 16'd0) begin
					if (vs > sec) ph = tlshx_pkg::PH_DONE;
					else begin
						ext = vs;
						if (!srv) begin
							tok_v = 1'b1; tok_k = tlshx_pkg::TK_EXT; tok_val = cet; tok_len = vs;
						end
						sb_go = 1'b1;
					end
				end else if (sec == 16'd0) ph = tlshx_pkg::PH_DONE;
			end else if (phase_q < tlshx_pkg::PH_DONE) begin
				// extension body
				if (sec != 16'd0) sec = sec - 16'd1;
				if (ext != 16'd0) ext = ext - 16'd1;
				unique case (ph0)
					tlshx_pkg::PH_SNI_LL, tlshx_pkg::PH_ALPN_LL, tlshx_pkg::PH_U16_LL: begin
						vs = v16;
						if (itm != 16'd0) itm = itm - 16'd1;
						if (itm == 16'd0) begin
							if (vs > ext || vs == 16'd0) ph = tlshx_pkg::PH_SKIP;
							else begin
								lst = vs;
								if (ph0 == tlshx_pkg::PH_SNI_LL) sni_go = 1'b1;
								else if (ph0 == tlshx_pkg::PH_ALPN_LL) ph = tlshx_pkg::PH_ALPN_LEN;
								else begin
									ph = tlshx_pkg::PH_U16_ITEMS; itm = '0;
								end
							end
						end
					end
					tlshx_pkg::PH_U8_LL: begin
						if ({8'd0, payload_byte} > ext || payload_byte == 8'd0)
							ph = tlshx_pkg::PH_SKIP;
						else begin
							lst = {8'd0, payload_byte}; itm = '0;
							ph = (cet == tlshx_pkg::EXT_PTFMT) ? tlshx_pkg::PH_PF_ITEMS
								: tlshx_pkg::PH_U16_ITEMS;
						end
					end
					tlshx_pkg::PH_U16_ITEMS: begin
						if (itm == 16'd0) begin
							vs = {8'd0, payload_byte}; itm = 16'd1;
						end else begin
							itm = '0;
							if (cet == tlshx_pkg::EXT_SIGALG) begin
								tok_v = 1'b1; tok_k = tlshx_pkg::TK_SIGALG; tok_val = v16;
							end else if (!tlshx_pkg::is_grease(v16)) begin
								tok_v = 1'b1; tok_val = v16;
								tok_k = (cet == tlshx_pkg::EXT_GROUPS) ? tlshx_pkg::TK_GROUP
									: tlshx_pkg::TK_VERSION;
							end
						end
						if (lst != 16'd0) lst = lst - 16'd1;
						if (lst == 16'd0) ph = tlshx_pkg::PH_SKIP;
					end
					tlshx_pkg::PH_PF_ITEMS: begin
						tok_v = 1'b1; tok_k = tlshx_pkg::TK_PTFMT; tok_val = {8'd0, payload_byte};
						if (lst != 16'd0) lst = lst - 16'd1;
						if (lst == 16'd0) ph = tlshx_pkg::PH_SKIP;
					end
					tlshx_pkg::PH_SNI_HDR: begin
						if (lst != 16'd0) lst = lst - 16'd1;
						if (itm == 16'd3) vs = '0;
						else vs = v16;
						itm = itm - 16'd1;
						if (itm == 16'd0) begin
							if (vs > ext) ph = tlshx_pkg::PH_SKIP;
							else if (vs == 16'd0) sni_go = 1'b1;
							else begin
								itm = vs; ph = tlshx_pkg::PH_SNI_NAME;
							end
						end
					end
					tlshx_pkg::PH_SNI_NAME: begin
						if (lst != 16'd0) lst = lst - 16'd1;
						tok_v = 1'b1; tok_k = tlshx_pkg::TK_SNI; tok_val = {8'd0, payload_byte};
						tok_end = (itm == 16'd1);
						itm = itm - 16'd1;
						if (itm == 16'd0) sni_go = 1'b1;
					end
					tlshx_pkg::PH_ALPN_LEN: begin
						if (lst != 16'd0) lst = lst - 16'd1;
						if ({8'd0, payload_byte} > lst) ph = tlshx_pkg::PH_SKIP;
						else if (payload_byte == 8'd0) begin
							if (lst == 16'd0) ph = tlshx_pkg::PH_SKIP;
						end else begin
							itm = {8'd0, payload_byte}; ph = tlshx_pkg::PH_ALPN_NAME;
						end
					end
					tlshx_pkg::PH_ALPN_NAME: begin
						if (lst != 16'd0) lst = lst - 16'd1;
						tok_v = 1'b1; tok_k = tlshx_pkg::TK_ALPN; tok_val = {8'd0, payload_byte};
						tok_end = (itm == 16'd1);
						itm = itm - 16'd1;
						if (itm == 16'd0)
							ph = (lst != 16'd0) ? tlshx_pkg::PH_ALPN_LEN : tlshx_pkg::PH_SKIP;
					end
					tlshx_pkg::PH_SRV_VER: begin
						vs = v16;
						if (itm != 16'd0) itm = itm - 16'd1;
						if (itm == 16'd0) begin
							tok_v = 1'b1; tok_k = tlshx_pkg::TK_VERSION; tok_val = vs;
							ph = tlshx_pkg::PH_SKIP;
						end
					end
					default: ;
				endcase
				// next server name entry
				if (sni_go) begin
					if (lst < 16'd3) ph = tlshx_pkg::PH_SKIP;
					else begin
						ph = tlshx_pkg::PH_SNI_HDR; itm = 16'd3; vs = '0;
					end
				end
				if (ext == 16'd0) ne_go = 1'b1;
			end
		end else if (phase_q <= tlshx_pkg::PH_EXTS_LEN) begin
			rej = 1'b1; ph = tlshx_pkg::PH_DRAIN;
		end
		// dispatch on extension type
		if (sb_go) begin
			if (ext == 16'd0) ne_go = 1'b1;
			else if (!srv && cet == tlshx_pkg::EXT_SNI) begin
				ph = tlshx_pkg::PH_SNI_LL; itm = 16'd2; vs = '0;
			end else if (cet == tlshx_pkg::EXT_ALPN) begin
				ph = tlshx_pkg::PH_ALPN_LL; itm = 16'd2; vs = '0;
			end else if (!srv && (cet == tlshx_pkg::EXT_GROUPS || cet == tlshx_pkg::EXT_SIGALG)) begin
				ph = tlshx_pkg::PH_U16_LL; itm = 16'd2; vs = '0;
			end else if (!srv && (cet == tlshx_pkg::EXT_PTFMT || cet == tlshx_pkg::EXT_VERSIONS))
				ph = tlshx_pkg::PH_U8_LL;
			else if (srv && cet == tlshx_pkg::EXT_VERSIONS) begin
				ph = tlshx_pkg::PH_SRV_VER; itm = 16'd2; vs = '0;
			end else ph = tlshx_pkg::PH_SKIP;
		end
		// next extension header
		if (ne_go) begin
			if (sec == 16'd0) ph = tlshx_pkg::PH_DONE;
			else begin
				ph = tlshx_pkg::PH_EXT_HDR; itm = 16'd4; vs = '0; cet = '0;
			end
		end
		if (off_q < OFF_MAX) off_n = off_q + PL'(1);
		ok = !rej && ph >= tlshx_pkg::PH_EXT_HDR && ph <= tlshx_pkg::PH_DONE;
	end

	// result queue
	tlshx_pkg::result_t fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	tlshx_pkg::result_t tok_r, ver_r;
	logic in_take, out_take;
	logic [2:0] n_push;

	assign in_ready = (cnt_q <= 3'd2);
	assign in_take  = in_valid && in_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign out_take  = out_valid && out_ready;
	assign n_push = in_take ? (3'(tok_v) + 3'(final_byte)) : 3'd0;

	assign tok_r = '{kind: tok_k, value: tok_val, elen: tok_len, nend: tok_end,
		last: !final_byte};
	assign ver_r = '{kind: ok ? tlshx_pkg::TK_ACCEPT : tlshx_pkg::TK_REJECT,
		value: 16'd0, elen: 16'd0, nend: 1'b0, last: 1'b1};

	assign token_kind  = fifo_q[rd_q].kind;
	assign token_value = fifo_q[rd_q].value;
	assign ext_length  = fifo_q[rd_q].elen;
	assign name_end    = fifo_q[rd_q].nend;
	assign run_last    = fifo_q[rd_q].last;

	// queue storage
	always_ff @(posedge clk) begin
		if (in_take) begin
			if (tok_v) begin
				fifo_q[wr_q] <= tok_r;
				if (final_byte) fifo_q[wr_q + 2'd1] <= ver_r;
			end else if (final_byte) fifo_q[wr_q] <= ver_r;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + n_push[1:0];
			if (out_take) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + n_push - 3'(out_take);
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlshx_pkg::PH_HDR;
			off_q <= '0;
			srv_q <= 1'b0;
			rej_q <= 1'b0;
			sec_q <= '0; ext_q <= '0; lst_q <= '0;
			itm_q <= '0; cet_q <= '0; vs_q <= '0;
		end else if (in_take) begin
			if (final_byte) begin
				phase_q <= tlshx_pkg::PH_HDR;
				off_q <= '0;
				srv_q <= 1'b0;
				rej_q <= 1'b0;
				sec_q <= '0; ext_q <= '0; lst_q <= '0;
				itm_q <= '0; cet_q <= '0; vs_q <= '0;
			end else begin
				phase_q <= ph;
				off_q <= off_n;
				srv_q <= srv;
				rej_q <= rej;
				sec_q <= sec; ext_q <= ext; lst_q <= lst;
				itm_q <= itm; cet_q <= cet; vs_q <= vs;
			end
		end
	end

endmodule
